// ----- rtl/spk_pkg.sv -----
// Package for the spiking neuron update block.
// Register indexes, reset values and field widths; no dependencies.
package spk_pkg;

    localparam int PotW    = 16;
    localparam int StepW   = 15;
    localparam int TicksW  = 16;
    localparam int TickW   = 32;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 16;
    localparam int InDataW  = 48;   // signal_power + tick_number
    localparam int OutDataW = 40;   // 34 used, padded to whole bytes

    typedef enum logic [CfgIdxW-1:0] {
        REG_SPIKE_LEVEL      = 3'd0,
        REG_MIN_POTENTIAL    = 3'd1,
        REG_MAX_POTENTIAL    = 3'd2,
        REG_BASE_POTENTIAL   = 3'd3,
        REG_RECOVERY_STEP    = 3'd4,
        REG_SPIKE_POWER      = 3'd5,
        REG_REFRACTORY_TICKS = 3'd6,
        REG_INHIBITORY       = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        REQ_SIGNAL = 1'b0,
        REQ_TICK   = 1'b1
    } req_type_t;

    localparam logic signed [PotW-1:0] RstSpikeLevel  = 16'sd100;
    localparam logic signed [PotW-1:0] RstMinPotential = -16'sd100;
    localparam logic signed [PotW-1:0] RstMaxPotential = 16'sd200;
    localparam logic signed [PotW-1:0] RstBasePotential = 16'sd0;
    localparam logic [StepW-1:0]       RstRecoveryStep = 15'd1;
    localparam logic [StepW-1:0]       RstSpikePower   = 15'd10;
    localparam logic [TicksW-1:0]      RstRefrTicks    = 16'd5;

endpackage

// ----- rtl/spiking_neuron_update.sv -----
// Spiking neuron update: integrate-and-fire neuron with linear leak and refractory period.
// Depends on spk_pkg.
//
// Path from request accept to result accept: input register, then result register.
// Throughput: one request per cycle unless a tick is held; signal requests give no result and never wait in it.
// A tick request waits in the input register only while the result register is full and
// not being taken. Reset (rst_n low, asynchronous) loads the register defaults, clears
// potential, pending potential and refractory end tick, and empties both stages.
module spiking_neuron_update
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [spk_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [spk_pkg::CfgW-1:0]       cfg_data,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [spk_pkg::InDataW-1:0]    s_tdata,  // signal_power[15:0], tick_number[47:16]
    input  logic                           s_tuser,  // req_type
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [spk_pkg::OutDataW-1:0]   m_tdata   // spike[0], recorded_potential[16:1],
                                                     // emitted_power[32:17], refractory[33]
);
    import spk_pkg::*;

    // configuration
    logic signed [PotW-1:0]  spike_level_reg;
    logic signed [PotW-1:0]  min_pot_reg;
    logic signed [PotW-1:0]  max_pot_reg;
    logic signed [PotW-1:0]  base_pot_reg;
    logic [StepW-1:0]        recovery_step_reg;
    logic [StepW-1:0]        spike_power_reg;
    logic [TicksW-1:0]       refr_ticks_reg;
    logic                    inhibitory_reg;

    // neuron state
    logic signed [PotW-1:0]  pot_reg, pot_next;
    logic signed [PotW-1:0]  pend_reg, pend_next;
    logic [TickW-1:0]        end_tick_reg, end_tick_next;

    // input stage
    logic                    in_valid_reg;
    req_type_t               in_type_reg;
    logic signed [PotW-1:0]  in_sig_reg;
    logic [TickW-1:0]        in_tick_reg;

    // result stage
    logic                    out_valid_reg;
    logic                    out_spike_reg, out_spike_next;
    logic signed [PotW-1:0]  out_rec_reg, out_rec_next;
    logic signed [PotW-1:0]  out_emit_reg, out_emit_next;
    logic                    out_refr_reg, out_refr_next;

    logic                    is_tick;
    logic                    advance;
    logic                    s_accept;

    logic signed [PotW:0]    sum;
    logic signed [PotW-1:0]  clamped;
    logic                    in_refr;
    logic                    fire;
    logic [TickW:0]          end_sum;
    logic signed [PotW+1:0]  rec_dn;
    logic signed [PotW+1:0]  rec_up;
    logic signed [PotW+1:0]  base_ext;
    logic signed [PotW+1:0]  pend_ext;

    assign is_tick  = (in_type_reg == REQ_TICK);
    // signals never need the result slot
    assign advance  = in_valid_reg && (!is_tick || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spike_level_reg   <= RstSpikeLevel;
            min_pot_reg       <= RstMinPotential;
            max_pot_reg       <= RstMaxPotential;
            base_pot_reg      <= RstBasePotential;
            recovery_step_reg <= RstRecoveryStep;
            spike_power_reg   <= RstSpikePower;
            refr_ticks_reg    <= RstRefrTicks;
            inhibitory_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SPIKE_LEVEL:      spike_level_reg   <= cfg_data;
                REG_MIN_POTENTIAL:    min_pot_reg       <= cfg_data;
                REG_MAX_POTENTIAL:    max_pot_reg       <= cfg_data;
                REG_BASE_POTENTIAL:   base_pot_reg      <= cfg_data;
                REG_RECOVERY_STEP:    recovery_step_reg <= cfg_data[StepW-1:0];
                REG_SPIKE_POWER:      spike_power_reg   <= cfg_data[StepW-1:0];
                REG_REFRACTORY_TICKS: refr_ticks_reg    <= cfg_data[TicksW-1:0];
                REG_INHIBITORY:       inhibitory_reg    <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_type_reg <= req_type_t'(s_tuser);
            in_sig_reg  <= s_tdata[PotW-1:0];
            in_tick_reg <= s_tdata[PotW +: TickW];
        end
    end

    // datapath
    always_comb
    begin
        sum      = {pend_reg[PotW-1], pend_reg} + {in_sig_reg[PotW-1], in_sig_reg};
        // lower bound is checked first; when min is above max, a sum below min gives min, any other gives max
        if (sum < $signed({min_pot_reg[PotW-1], min_pot_reg}))
            clamped = min_pot_reg;
        else if (sum > $signed({max_pot_reg[PotW-1], max_pot_reg}))
            clamped = max_pot_reg;
        else
            clamped = sum[PotW-1:0];

        in_refr  = end_tick_reg > in_tick_reg;
        fire     = pend_reg >= spike_level_reg;
        end_sum  = {1'b0, in_tick_reg} + {{(TickW-TicksW+1){1'b0}}, refr_ticks_reg};
        base_ext = {{2{base_pot_reg[PotW-1]}}, base_pot_reg};
        pend_ext = {{2{pend_reg[PotW-1]}}, pend_reg};
        rec_dn   = pend_ext - {3'b000, recovery_step_reg};
        rec_up   = pend_ext + {3'b000, recovery_step_reg};

        pot_next       = pot_reg;
        pend_next      = pend_reg;
        end_tick_next  = end_tick_reg;
        out_spike_next = 1'b0;
        out_rec_next   = '0;
        out_emit_next  = '0;
        out_refr_next  = 1'b0;

        if (!is_tick)
        begin
            pend_next = clamped;
        end
        else if (in_refr)
        begin
            // pending signals dropped
            pend_next     = pot_reg;
            out_refr_next = 1'b1;
        end
        else
        begin
            out_rec_next = pend_reg;
            if (fire)
            begin
                out_spike_next = 1'b1;
                out_emit_next  = inhibitory_reg ? -$signed({1'b0, spike_power_reg})
                                                :  $signed({1'b0, spike_power_reg});
                end_tick_next  = end_sum[TickW] ? {TickW{1'b1}} : end_sum[TickW-1:0];
                pot_next       = base_pot_reg;
            end
            else if (pend_reg > base_pot_reg)
            begin
                pot_next = (rec_dn < base_ext) ? base_pot_reg : rec_dn[PotW-1:0];
            end
            else if (pend_reg < base_pot_reg)
            begin
                pot_next = (rec_up > base_ext) ? base_pot_reg : rec_up[PotW-1:0];
            end
            else
            begin
                pot_next = pend_reg;
            end
            pend_next = pot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pot_reg      <= '0;
            pend_reg     <= '0;
            end_tick_reg <= '0;
        end
        else if (advance)
        begin
            pot_reg      <= pot_next;
            pend_reg     <= pend_next;
            end_tick_reg <= end_tick_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_tick)
        begin
            out_spike_reg <= out_spike_next;
            out_rec_reg   <= out_rec_next;
            out_emit_reg  <= out_emit_next;
            out_refr_reg  <= out_refr_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW-2*PotW-2){1'b0}}, out_refr_reg, out_emit_reg,
                       out_rec_reg, out_spike_reg};

endmodule
